[sv/led_ser_pkg.sv]
// Shared types, codes and constants of the addressable LED serializer.
package led_ser_pkg;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [2:0] CFG_ONE_HIGH  = 3'd0;
  localparam logic [2:0] CFG_ONE_LOW   = 3'd1;
  localparam logic [2:0] CFG_ZERO_HIGH = 3'd2;
  localparam logic [2:0] CFG_ZERO_LOW  = 3'd3;
  localparam logic [2:0] CFG_LEAD_LOW  = 3'd4;

  localparam logic [15:0] RST_ONE_HIGH  = 16'd30;
  localparam logic [15:0] RST_ONE_LOW   = 16'd26;
  localparam logic [15:0] RST_ZERO_HIGH = 16'd11;
  localparam logic [15:0] RST_ZERO_LOW  = 16'd43;
  localparam logic [15:0] RST_LEAD_LOW  = 16'd6400;

  localparam logic [1:0] COLOR_GREEN = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } result_t;

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    at_least_one = (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

[sv/led_ser_skid.sv]
// Two-entry output register with skid stage for result transactions.
module led_ser_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  led_ser_pkg::result_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output led_ser_pkg::result_t out_data
);

  logic                 main_valid;
  led_ser_pkg::result_t main_data;
  logic                 skid_valid;
  led_ser_pkg::result_t skid_data;
  logic                 push;
  logic                 pop;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign push      = in_valid && !skid_valid;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data <= in_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= in_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

[sv/addressable_led_serializer.sv]
// Top level of the addressable LED serializer.
//
// Each input transaction carries one action in s_axis_tuser: set one LED
// color, start a frame, or advance time by one clock tick. Every accepted
// transaction produces exactly one result transaction on the master side,
// carrying the data line level, the busy flag, the rejected flag and, on
// m_axis_tlast, the end-of-frame mark.
// A result is registered in the output stage when its transaction is accepted.
// One transaction is accepted per cycle while s_axis_tready is high; the whole
// update of the send state is done in a single pass between the state registers and the output register.
// A two-entry output register lets the block keep accepting while one result
// waits; s_axis_tready drops only when both entries are full, so a stalled
// receiver stalls the input after two results.
// Reset clears the color store to zero, returns the sender to idle with the
// line low, restores the default pulse timings and empties the output stage.
// Configuration writes on cfg_we take effect at the next phase load.
module addressable_led_serializer #(
  parameter int LED_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // led_addr[2:0], red[10:3], green[18:11], blue[26:19]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // line_level[0], busy_res[1], rejected[2]
  output logic        m_axis_tlast,  // frame_done
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [3:0] LED_LIMIT = 4'(LED_COUNT);
  localparam logic [LW-1:0] LED_LAST = LW'(LED_COUNT - 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEAD = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_LOW  = 2'd3;

  logic [15:0] one_high_ticks;
  logic [15:0] one_low_ticks;
  logic [15:0] zero_high_ticks;
  logic [15:0] zero_low_ticks;
  logic [15:0] lead_low_ticks;

  logic [23:0] color_store [LED_COUNT];

  logic [1:0]    phase;
  logic [1:0]    phase_next;
  logic [15:0]   ticks_left;
  logic [15:0]   ticks_left_next;
  logic [2:0]    bit_pos;
  logic [2:0]    bit_pos_next;
  logic [1:0]    color_pos;
  logic [1:0]    color_pos_next;
  logic [LW-1:0] led_pos;
  logic [LW-1:0] led_pos_next;

  logic [1:0]  action;
  logic [2:0]  led_addr;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        accept;
  logic        busy;
  logic        set_en;
  logic        done;
  logic        rej;
  logic [15:0] ticks_dec;

  logic [2:0]    adv_bit;
  logic [1:0]    adv_color;
  logic [LW-1:0] adv_led;
  logic          last_bit;
  logic [2:0]    look_bit;
  logic [1:0]    look_color;
  logic [LW-1:0] look_led;
  logic [23:0]   look_word;
  logic [7:0]    look_byte;
  logic          cur_val;

  led_ser_pkg::result_t res;
  led_ser_pkg::result_t out_res;
  logic                 q_ready;

  assign action    = s_axis_tuser;
  assign led_addr  = s_axis_tdata[2:0];
  assign red       = s_axis_tdata[10:3];
  assign green     = s_axis_tdata[18:11];
  assign blue      = s_axis_tdata[26:19];

  assign s_axis_tready = q_ready;
  assign accept        = s_axis_tvalid && q_ready;
  assign busy          = (phase != PH_IDLE);
  assign ticks_dec     = (ticks_left != 16'd0) ? ticks_left - 16'd1 : 16'd0;

  // Position of the bit that follows the one ending its low phase.
  always_comb begin
    adv_led   = led_pos;
    adv_color = color_pos;
    adv_bit   = bit_pos - 3'd1;
    if (bit_pos == 3'd0) begin
      adv_bit = 3'd7;
      if (color_pos == led_ser_pkg::COLOR_BLUE) begin
        adv_color = led_ser_pkg::COLOR_GREEN;
        adv_led   = led_pos + LW'(1);
      end else begin
        adv_color = color_pos + 2'd1;
      end
    end
  end

  assign last_bit = (bit_pos == 3'd0) && (color_pos == led_ser_pkg::COLOR_BLUE) &&
                    (led_pos == LED_LAST);

  always_comb begin
    case (phase)
      PH_LEAD: begin
        look_led   = '0;
        look_color = led_ser_pkg::COLOR_GREEN;
        look_bit   = 3'd7;
      end
      PH_LOW: begin
        look_led   = adv_led;
        look_color = adv_color;
        look_bit   = adv_bit;
      end
      default: begin
        look_led   = led_pos;
        look_color = color_pos;
        look_bit   = bit_pos;
      end
    endcase
  end

  assign look_word = color_store[look_led];

  always_comb begin
    case (look_color)
      led_ser_pkg::COLOR_GREEN: look_byte = look_word[23:16];
      led_ser_pkg::COLOR_RED:   look_byte = look_word[15:8];
      led_ser_pkg::COLOR_BLUE:  look_byte = look_word[7:0];
      default:                  look_byte = 8'd0;
    endcase
  end

  assign cur_val = look_byte[look_bit];

  always_comb begin
    phase_next      = phase;
    ticks_left_next = ticks_left;
    bit_pos_next    = bit_pos;
    color_pos_next  = color_pos;
    led_pos_next    = led_pos;
    set_en          = 1'b0;
    done            = 1'b0;
    rej             = 1'b0;
    if (accept) begin
      case (action)
        led_ser_pkg::ACT_SET: begin
          if (busy || ({1'b0, led_addr} >= LED_LIMIT)) begin
            rej = 1'b1;
          end else begin
            set_en = 1'b1;
          end
        end
        led_ser_pkg::ACT_START: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            phase_next      = PH_LEAD;
            ticks_left_next = led_ser_pkg::at_least_one(lead_low_ticks);
            bit_pos_next    = 3'd7;
            color_pos_next  = led_ser_pkg::COLOR_GREEN;
            led_pos_next    = '0;
          end
        end
        led_ser_pkg::ACT_TICK: begin
          if (busy) begin
            ticks_left_next = ticks_dec;
            if (ticks_dec == 16'd0) begin
              case (phase)
                PH_LEAD: begin
                  phase_next      = PH_HIGH;
                  bit_pos_next    = 3'd7;
                  color_pos_next  = led_ser_pkg::COLOR_GREEN;
                  led_pos_next    = '0;
                  ticks_left_next = led_ser_pkg::at_least_one(
                                      cur_val ? one_high_ticks : zero_high_ticks);
                end
                PH_HIGH: begin
                  phase_next      = PH_LOW;
                  ticks_left_next = led_ser_pkg::at_least_one(
                                      cur_val ? one_low_ticks : zero_low_ticks);
                end
                default: begin
                  if (last_bit) begin
                    phase_next      = PH_IDLE;
                    ticks_left_next = 16'd0;
                    bit_pos_next    = 3'd7;
                    color_pos_next  = led_ser_pkg::COLOR_GREEN;
                    led_pos_next    = '0;
                    done            = 1'b1;
                  end else begin
                    phase_next      = PH_HIGH;
                    bit_pos_next    = adv_bit;
                    color_pos_next  = adv_color;
                    led_pos_next    = adv_led;
                    ticks_left_next = led_ser_pkg::at_least_one(
                                        cur_val ? one_high_ticks : zero_high_ticks);
                  end
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      ticks_left <= 16'd0;
      bit_pos    <= 3'd7;
      color_pos  <= led_ser_pkg::COLOR_GREEN;
      led_pos    <= '0;
    end else begin
      phase      <= phase_next;
      ticks_left <= ticks_left_next;
      bit_pos    <= bit_pos_next;
      color_pos  <= color_pos_next;
      led_pos    <= led_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        color_store[i] <= 24'd0;
      end
    end else if (set_en) begin
      color_store[led_addr[LW-1:0]] <= {green, red, blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high_ticks  <= led_ser_pkg::RST_ONE_HIGH;
      one_low_ticks   <= led_ser_pkg::RST_ONE_LOW;
      zero_high_ticks <= led_ser_pkg::RST_ZERO_HIGH;
      zero_low_ticks  <= led_ser_pkg::RST_ZERO_LOW;
      lead_low_ticks  <= led_ser_pkg::RST_LEAD_LOW;
    end else if (cfg_we) begin
      case (cfg_index)
        led_ser_pkg::CFG_ONE_HIGH:  one_high_ticks  <= cfg_data;
        led_ser_pkg::CFG_ONE_LOW:   one_low_ticks   <= cfg_data;
        led_ser_pkg::CFG_ZERO_HIGH: zero_high_ticks <= cfg_data;
        led_ser_pkg::CFG_ZERO_LOW:  zero_low_ticks  <= cfg_data;
        led_ser_pkg::CFG_LEAD_LOW:  lead_low_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign res.line_level = (phase_next == PH_HIGH);
  assign res.busy_res   = (phase_next != PH_IDLE);
  assign res.frame_done = done;
  assign res.rejected   = rej;

  led_ser_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (q_ready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.rejected, out_res.busy_res, out_res.line_level};
  assign m_axis_tlast = out_res.frame_done;

endmodule

[sv/led_ser_chk.sv]
// Port checker for the addressable LED serializer and its bind statement.
module led_ser_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  a_no_out_after_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Result transaction present right after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Stalled result transaction changed.");

  a_high_needs_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("Line driven high while the sender is idle.");

  a_done_is_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[1] && !m_axis_tdata[2])
    else $error("Frame end reported while busy or together with a rejection.");

endmodule

bind addressable_led_serializer led_ser_chk u_led_ser_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[test/addressable_led_serializer_test.sv]
// Self-checking testbench for the addressable LED serializer with a line-timing predictor.
module addressable_led_serializer_test;

  localparam int LEDS = 3;
  localparam int TOTAL_ITEMS = 1900;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [2:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CFG_UNUSED_LAST = 3'd7;

  typedef enum logic [1:0] {SEND_IDLE, SEND_LEAD, SEND_HIGH, SEND_LOW} send_phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] led_addr;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  addressable_led_serializer #(.LED_COUNT(LEDS)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predicted state of the serializer.
  logic [7:0]  color_bytes [LEDS*3];
  logic [15:0] timing [5];
  send_phase_t line_phase;
  logic [15:0] ticks_left;
  logic [2:0]  bit_pos;
  logic [3:0]  byte_pos;

  led_cmd_t             led_cmds[$];
  led_ser_pkg::result_t levels_due[$];
  led_cmd_t             in_flight;
  led_ser_pkg::result_t want;
  int gap_left = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;
  int taken_items = 0;
  int fails = 0;
  int cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int draw_gap(inout bit calm);
    int r;
    if ($urandom_range(0, 149) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 97) return $urandom_range(1, 2);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [15:0] pulse_ticks(input logic high_half);
    logic one;
    logic [15:0] v;
    one = color_bytes[byte_pos][bit_pos];
    if (high_half) begin
      v = one ? timing[led_ser_pkg::CFG_ONE_HIGH] : timing[led_ser_pkg::CFG_ZERO_HIGH];
    end else begin
      v = one ? timing[led_ser_pkg::CFG_ONE_LOW] : timing[led_ser_pkg::CFG_ZERO_LOW];
    end
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic led_ser_pkg::result_t step_line_model(input led_cmd_t c);
    led_ser_pkg::result_t r;
    logic busy;
    busy = (line_phase != SEND_IDLE);
    r = '0;
    case (c.action)
      led_ser_pkg::ACT_SET: begin
        if (busy || c.led_addr >= LEDS) begin
          r.rejected = 1'b1;
        end else begin
          color_bytes[c.led_addr * 3 + led_ser_pkg::COLOR_GREEN] = c.green;
          color_bytes[c.led_addr * 3 + led_ser_pkg::COLOR_RED] = c.red;
          color_bytes[c.led_addr * 3 + led_ser_pkg::COLOR_BLUE] = c.blue;
        end
      end
      led_ser_pkg::ACT_START: begin
        if (busy) begin
          r.rejected = 1'b1;
        end else begin
          line_phase = SEND_LEAD;
          ticks_left = (timing[led_ser_pkg::CFG_LEAD_LOW] == 16'd0) ? 16'd1
                                                                    : timing[led_ser_pkg::CFG_LEAD_LOW];
          bit_pos = 3'd7;
          byte_pos = 4'd0;
        end
      end
      led_ser_pkg::ACT_TICK: begin
        if (busy) begin
          if (ticks_left != 16'd0) ticks_left--;
          if (ticks_left == 16'd0) begin
            case (line_phase)
              SEND_LEAD: begin
                bit_pos = 3'd7;
                byte_pos = 4'd0;
                line_phase = SEND_HIGH;
                ticks_left = pulse_ticks(1'b1);
              end
              SEND_HIGH: begin
                line_phase = SEND_LOW;
                ticks_left = pulse_ticks(1'b0);
              end
              default: begin
                if (bit_pos != 3'd0) begin
                  bit_pos--;
                  line_phase = SEND_HIGH;
                  ticks_left = pulse_ticks(1'b1);
                end else if (int'(byte_pos) + 1 < LEDS * 3) begin
                  bit_pos = 3'd7;
                  byte_pos++;
                  line_phase = SEND_HIGH;
                  ticks_left = pulse_ticks(1'b1);
                end else begin
                  line_phase = SEND_IDLE;
                  ticks_left = 16'd0;
                  bit_pos = 3'd7;
                  byte_pos = 4'd0;
                  r.frame_done = 1'b1;
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    r.line_level = (line_phase == SEND_HIGH);
    r.busy_res = (line_phase != SEND_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        levels_due.push_back(step_line_model(in_flight));
        taken_items++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (led_cmds.size() != 0) begin
          in_flight = led_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= in_flight.action;
          s_axis_tdata <= {5'd0, in_flight.blue, in_flight.green, in_flight.red,
                           in_flight.led_addr};
          gap_left = draw_gap(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (levels_due.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fails++;
        end else begin
          want = levels_due.pop_front();
          if (m_axis_tdata[0] !== want.line_level) begin
            $error("line_level: expected %0b, got %0b", want.line_level, m_axis_tdata[0]);
            fails++;
          end
          if (m_axis_tdata[1] !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, m_axis_tdata[1]);
            fails++;
          end
          if (m_axis_tdata[2] !== want.rejected) begin
            $error("rejected: expected %0b, got %0b", want.rejected, m_axis_tdata[2]);
            fails++;
          end
          if (m_axis_tlast !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done, m_axis_tlast);
            fails++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = draw_gap(take_calm);
      end
    end
  end

  function automatic led_cmd_t led_cmd(input logic [1:0] action, input logic [2:0] idx,
                                       input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    led_cmd_t c;
    c.action = action;
    c.led_addr = idx;
    c.red = r;
    c.green = g;
    c.blue = b;
    return c;
  endfunction

  function automatic led_cmd_t random_cmd();
    return led_cmd(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
  endfunction

  function automatic logic [15:0] pick_ticks(input bit lead);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (lead) return 16'($urandom_range(1, 40));
    if (r < 68) return 16'd1;
    if (r < 94) return 16'($urandom_range(2, 3));
    return 16'($urandom_range(4, 12));
  endfunction

  task automatic write_timing(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx <= led_ser_pkg::CFG_LEAD_LOW) timing[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all_timing(input logic [15:0] one_high, input logic [15:0] one_low,
                                  input logic [15:0] zero_high, input logic [15:0] zero_low,
                                  input logic [15:0] lead);
    write_timing(led_ser_pkg::CFG_ONE_HIGH, one_high);
    write_timing(led_ser_pkg::CFG_ONE_LOW, one_low);
    write_timing(led_ser_pkg::CFG_ZERO_HIGH, zero_high);
    write_timing(led_ser_pkg::CFG_ZERO_LOW, zero_low);
    write_timing(led_ser_pkg::CFG_LEAD_LOW, lead);
  endtask

  task automatic settle_inputs();
    do @(negedge clk); while (led_cmds.size() != 0 || s_axis_tvalid);
  endtask

  task automatic settle_all();
    do @(negedge clk);
    while (led_cmds.size() != 0 || s_axis_tvalid || levels_due.size() != 0);
  endtask

  // Starts a frame and keeps feeding ticks, with stray commands mixed in, until it ends.
  task automatic play_frame(input int noise_pct);
    int n;
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_START, '0, '0, '0, '0));
    settle_inputs();
    while (line_phase != SEND_IDLE) begin
      n = int'(ticks_left) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      repeat (n) begin
        if ($urandom_range(1, 100) <= noise_pct) led_cmds.push_back(random_cmd());
        led_cmds.push_back(led_cmd(led_ser_pkg::ACT_TICK, '0, '0, '0, '0));
      end
      settle_inputs();
    end
  endtask

  initial begin
    foreach (color_bytes[i]) color_bytes[i] = 8'd0;
    timing[led_ser_pkg::CFG_ONE_HIGH] = led_ser_pkg::RST_ONE_HIGH;
    timing[led_ser_pkg::CFG_ONE_LOW] = led_ser_pkg::RST_ONE_LOW;
    timing[led_ser_pkg::CFG_ZERO_HIGH] = led_ser_pkg::RST_ZERO_HIGH;
    timing[led_ser_pkg::CFG_ZERO_LOW] = led_ser_pkg::RST_ZERO_LOW;
    timing[led_ser_pkg::CFG_LEAD_LOW] = led_ser_pkg::RST_LEAD_LOW;
    line_phase = SEND_IDLE;
    ticks_left = 16'd0;
    bit_pos = 3'd7;
    byte_pos = 4'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Idle tick, unused action code and out-of-range sets.
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_TICK, '0, '0, '0, '0));
    led_cmds.push_back(led_cmd(ACT_NONE, 3'd7, 8'hFF, 8'hFF, 8'hFF));
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'(LEDS), 8'hFF, 8'hFF, 8'hFF));
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'd7, 8'h5A, 8'hA5, 8'h3C));
    settle_all();

    // A frame of the color store as it comes out of reset.
    write_all_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    play_frame(2);
    settle_all();

    // Zero timings count as one; writes past the last register are dropped.
    write_all_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    write_timing(CFG_UNUSED_FIRST, 16'd1);
    write_timing(CFG_UNUSED_LAST, 16'hFFFF);
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'd0, 8'hFF, 8'h00, 8'hFF));
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'd1, 8'h00, 8'hFF, 8'h00));
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'(LEDS - 1), 8'hAA, 8'h55, 8'h81));
    play_frame(20);
    settle_all();

    write_all_timing(16'd3, 16'd2, 16'd1, 16'd4, 16'd2);
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'd0, 8'h01, 8'h80, 8'h7F));
    play_frame(10);
    settle_all();

    // A lead gap wider than eight bits ahead of a single set bit.
    write_all_timing(16'd2, 16'd3, 16'd1, 16'd1, 16'h0101);
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'd0, 8'h00, 8'h80, 8'h00));
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'd1, 8'h00, 8'h00, 8'h00));
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'd2, 8'h00, 8'h00, 8'h00));
    play_frame(1);
    settle_all();

    // Long zero-bit timings on the very last bit of the frame.
    write_all_timing(16'd1, 16'd1, 16'd20, 16'd30, 16'd1);
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'd0, 8'hFF, 8'hFF, 8'hFF));
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'd1, 8'hFF, 8'hFF, 8'hFF));
    led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET, 3'd2, 8'hFF, 8'hFF, 8'hFE));
    play_frame(1);
    settle_all();

    while (taken_items < TOTAL_ITEMS) begin
      for (int k = led_ser_pkg::CFG_ONE_HIGH; k <= led_ser_pkg::CFG_LEAD_LOW; k++) begin
        write_timing(3'(k), pick_ticks(k == led_ser_pkg::CFG_LEAD_LOW));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_timing(3'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)), 16'($urandom));
      end
      repeat ($urandom_range(0, 5)) begin
        led_cmds.push_back(led_cmd(led_ser_pkg::ACT_SET,
            ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, LEDS - 1))
                                       : 3'($urandom_range(LEDS, 7)),
            8'($urandom), 8'($urandom), 8'($urandom)));
      end
      if ($urandom_range(0, 4) == 0) led_cmds.push_back(random_cmd());
      play_frame(8);
      settle_all();
    end

    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
sv/led_ser_pkg.sv
sv/led_ser_skid.sv
sv/addressable_led_serializer.sv
sv/led_ser_chk.sv
test/addressable_led_serializer_test.sv
